// ===== design/kmp_pkg.sv =====
package kmp_pkg;

   localparam int SYMBOL_W = 8;
   localparam int START_W  = 20;

   // input action codes
   localparam logic ACT_PATTERN = 1'b0;
   localparam logic ACT_TEXT    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_INIT,
      ST_BUILD,
      ST_MATCH,
      ST_HIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [START_W-1:0] match_start;
      logic               is_match;
      logic               any_found;
      logic               last_result;
   } result_type;

endpackage

// ===== design/kmp_ram.sv =====
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kmp_ctrl.sv =====
module kmp_ctrl #(
   parameter int PATTERN_MAX   = 64,
   parameter int POSITION_BITS = 20,
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [kmp_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                          req_final_symbol,
   output logic                          pat_we,
   output logic [IDX_W-1:0]              pat_waddr,
   output logic [kmp_pkg::SYMBOL_W-1:0]  pat_wdata,
   output logic [IDX_W-1:0]              pat_raddr_a,
   input  logic [kmp_pkg::SYMBOL_W-1:0]  pat_rdata_a,
   output logic [IDX_W-1:0]              pat_raddr_b,
   input  logic [kmp_pkg::SYMBOL_W-1:0]  pat_rdata_b,
   output logic                          fail_we,
   output logic [IDX_W-1:0]              fail_waddr,
   output logic [IDX_W-1:0]              fail_wdata,
   output logic [IDX_W-1:0]              fail_raddr,
   input  logic [IDX_W-1:0]              fail_rdata,
   output logic                          emit_valid,
   input  logic                          emit_ready,
   output kmp_pkg::result_type           emit_data
);

   localparam int WIDE_W = (POSITION_BITS > kmp_pkg::START_W) ?
                           POSITION_BITS : kmp_pkg::START_W;

   kmp_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0]             len_ff, len_in;
   logic                         ready_ff, ready_in;
   logic [LEN_W-1:0]             m_ff, m_in;
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic                         found_ff, found_in;
   logic [LEN_W-1:0]             i_ff, i_in;
   logic [LEN_W-1:0]             k_ff, k_in;
   logic [kmp_pkg::SYMBOL_W-1:0] sym_ff, sym_in;
   logic                         fin_ff, fin_in;
   logic [POSITION_BITS-1:0]     idx_ff, idx_in;
   logic                         hit_ff, hit_in;

   logic                         accept;
   logic [LEN_W-1:0]             base_len;
   logic [LEN_W-1:0]             m_next;
   logic [LEN_W-1:0]             m_dec;
   logic [LEN_W-1:0]             k_dec;
   logic [LEN_W-1:0]             len_dec;
   logic [kmp_pkg::SYMBOL_W-1:0] operand_b;
   logic                         eq;
   logic [WIDE_W-1:0]            start_wide;

   // shared byte comparator: pattern vs pattern while building, pattern vs text after
   assign operand_b = (state_ff == kmp_pkg::ST_BUILD) ? pat_rdata_b : sym_ff;
   assign eq        = (pat_rdata_a == operand_b);

   assign accept    = req_valid && req_ready;
   assign start_wide = WIDE_W'(idx_ff) + WIDE_W'(1) - WIDE_W'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmp_pkg::ST_IDLE;
         len_ff   <= '0;
         ready_ff <= 1'b0;
         m_ff     <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         ready_ff <= ready_in;
         m_ff     <= m_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      k_ff   <= k_in;
      sym_ff <= sym_in;
      fin_ff <= fin_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      ready_in   = ready_ff;
      m_in       = m_ff;
      pos_in     = pos_ff;
      found_in   = found_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      sym_in     = sym_ff;
      fin_in     = fin_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      base_len   = len_ff;
      m_next     = m_ff;
      req_ready  = 1'b0;
      pat_we     = 1'b0;
      pat_waddr  = '0;
      pat_wdata  = req_symbol;
      fail_we    = 1'b0;
      fail_waddr = i_ff[IDX_W-1:0];
      fail_wdata = '0;
      emit_valid = 1'b0;
      emit_data  = '0;

      unique case (state_ff)
         kmp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_action == kmp_pkg::ACT_PATTERN) begin
                  // a byte after a complete pattern starts a new one
                  base_len = ready_ff ? '0 : len_ff;
                  if (ready_ff) begin
                     ready_in = 1'b0;
                     m_in     = '0;
                     pos_in   = '0;
                     found_in = 1'b0;
                  end
                  len_in = base_len;
                  if (base_len < LEN_W'(PATTERN_MAX)) begin
                     pat_we    = 1'b1;
                     pat_waddr = base_len[IDX_W-1:0];
                     len_in    = base_len + LEN_W'(1);
                  end
                  if (req_final_symbol) begin
                     ready_in = 1'b1;
                     m_in     = '0;
                     pos_in   = '0;
                     found_in = 1'b0;
                     state_in = kmp_pkg::ST_BUILD_INIT;
                  end
               end else begin
                  idx_in = pos_ff;
                  if (pos_ff != {POSITION_BITS{1'b1}}) begin
                     pos_in = pos_ff + POSITION_BITS'(1);
                  end
                  sym_in = req_symbol;
                  fin_in = req_final_symbol;
                  hit_in = 1'b0;
                  if (ready_ff && (len_ff != '0)) begin
                     state_in = kmp_pkg::ST_MATCH;
                  end else if (req_final_symbol) begin
                     state_in = kmp_pkg::ST_EMIT;
                  end
               end
            end
         end

         kmp_pkg::ST_BUILD_INIT: begin
            fail_we    = 1'b1;
            fail_waddr = '0;
            fail_wdata = '0;
            i_in       = LEN_W'(1);
            k_in       = '0;
            state_in   = (len_ff > LEN_W'(1)) ? kmp_pkg::ST_BUILD : kmp_pkg::ST_IDLE;
         end

         kmp_pkg::ST_BUILD: begin
            if (eq) begin
               k_in       = k_ff + LEN_W'(1);
               fail_we    = 1'b1;
               fail_wdata = k_in[IDX_W-1:0];
               i_in       = i_ff + LEN_W'(1);
            end else if (k_ff == '0) begin
               fail_we    = 1'b1;
               fail_wdata = '0;
               i_in       = i_ff + LEN_W'(1);
            end else begin
               k_in = LEN_W'(fail_rdata);
            end
            if (i_in >= len_ff) begin
               state_in = kmp_pkg::ST_IDLE;
            end
         end

         kmp_pkg::ST_MATCH: begin
            if ((m_ff != '0) && !eq) begin
               // fall back one table step and compare again
               m_in = LEN_W'(fail_rdata);
            end else begin
               m_next = eq ? (m_ff + LEN_W'(1)) : m_ff;
               m_in   = m_next;
               if (m_next == len_ff) begin
                  hit_in   = 1'b1;
                  found_in = 1'b1;
                  state_in = kmp_pkg::ST_HIT;
               end else begin
                  state_in = fin_ff ? kmp_pkg::ST_EMIT : kmp_pkg::ST_IDLE;
               end
            end
         end

         kmp_pkg::ST_HIT: begin
            // table entry of the last pattern byte keeps overlapping matches
            m_in     = LEN_W'(fail_rdata);
            state_in = kmp_pkg::ST_EMIT;
         end

         kmp_pkg::ST_EMIT: begin
            emit_valid            = 1'b1;
            emit_data.match_start = hit_ff ? start_wide[kmp_pkg::START_W-1:0] : '0;
            emit_data.is_match    = hit_ff;
            emit_data.any_found   = hit_ff || found_ff;
            emit_data.last_result = fin_ff;
            if (emit_ready) begin
               state_in = kmp_pkg::ST_IDLE;
               if (fin_ff) begin
                  m_in     = '0;
                  pos_in   = '0;
                  found_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = kmp_pkg::ST_IDLE;
         end
      endcase
   end

   // read addresses follow next-cycle values so data is ready on entry
   assign m_dec   = m_in - LEN_W'(1);
   assign k_dec   = k_in - LEN_W'(1);
   assign len_dec = len_ff - LEN_W'(1);

   always_comb begin
      pat_raddr_a = m_in[IDX_W-1:0];
      fail_raddr  = m_dec[IDX_W-1:0];
      if (state_in == kmp_pkg::ST_BUILD) begin
         pat_raddr_a = i_in[IDX_W-1:0];
         fail_raddr  = k_dec[IDX_W-1:0];
      end else if (state_in == kmp_pkg::ST_HIT) begin
         fail_raddr  = len_dec[IDX_W-1:0];
      end
   end

   assign pat_raddr_b = k_in[IDX_W-1:0];

endmodule

// ===== design/kmp_pattern_matcher_unit.sv =====
// kmp string search: pattern bytes are stored as accepted; the final pattern byte
// starts the prefix table build, ready low meanwhile
// a text byte holds ready low in the match state (skipped with no complete pattern),
// repeated per fallback step, then the hit state for a reported match and the emit state
// for a match or end marker, plus any wait for the output slot; results are registered
// synchronous reset clears pattern length and text state; memories are not cleared
module kmp_pattern_matcher_unit #(
   parameter int PATTERN_MAX   = 64,
   parameter int POSITION_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [kmp_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                          req_final_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kmp_pkg::START_W-1:0]   rsp_match_start,
   output logic                          rsp_is_match,
   output logic                          rsp_any_found,
   output logic                          rsp_last_result
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   // pattern memory write side, shared by both read copies
   logic                         pat_we;
   logic [IDX_W-1:0]             pat_waddr;
   logic [kmp_pkg::SYMBOL_W-1:0] pat_wdata;
   logic [IDX_W-1:0]             pat_raddr_a;
   logic [kmp_pkg::SYMBOL_W-1:0] pat_rdata_a;
   logic [IDX_W-1:0]             pat_raddr_b;
   logic [kmp_pkg::SYMBOL_W-1:0] pat_rdata_b;

   // prefix table
   logic                         fail_we;
   logic [IDX_W-1:0]             fail_waddr;
   logic [IDX_W-1:0]             fail_wdata;
   logic [IDX_W-1:0]             fail_raddr;
   logic [IDX_W-1:0]             fail_rdata;

   // result handoff from the sequencer
   logic                         emit_valid;
   logic                         emit_ready;
   kmp_pkg::result_type          emit_data;

   // output register, parts the sequencer from the result channel
   logic                         rsp_valid_ff, rsp_valid_in;
   kmp_pkg::result_type          rsp_data_ff, rsp_data_in;

   kmp_ctrl #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_symbol       (req_symbol),
      .req_final_symbol (req_final_symbol),
      .pat_we           (pat_we),
      .pat_waddr        (pat_waddr),
      .pat_wdata        (pat_wdata),
      .pat_raddr_a      (pat_raddr_a),
      .pat_rdata_a      (pat_rdata_a),
      .pat_raddr_b      (pat_raddr_b),
      .pat_rdata_b      (pat_rdata_b),
      .fail_we          (fail_we),
      .fail_waddr       (fail_waddr),
      .fail_wdata       (fail_wdata),
      .fail_raddr       (fail_raddr),
      .fail_rdata       (fail_rdata),
      .emit_valid       (emit_valid),
      .emit_ready       (emit_ready),
      .emit_data        (emit_data)
   );

   // two copies of the pattern store give the table build two read ports
   kmp_ram #(
      .WIDTH (kmp_pkg::SYMBOL_W),
      .DEPTH (PATTERN_MAX)
   ) u_pattern_a (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_waddr),
      .wr_data (pat_wdata),
      .rd_addr (pat_raddr_a),
      .rd_data (pat_rdata_a)
   );

   kmp_ram #(
      .WIDTH (kmp_pkg::SYMBOL_W),
      .DEPTH (PATTERN_MAX)
   ) u_pattern_b (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_waddr),
      .wr_data (pat_wdata),
      .rd_addr (pat_raddr_b),
      .rd_data (pat_rdata_b)
   );

   kmp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (PATTERN_MAX)
   ) u_fail (
      .clock   (clock),
      .wr_en   (fail_we),
      .wr_addr (fail_waddr),
      .wr_data (fail_wdata),
      .rd_addr (fail_raddr),
      .rd_data (fail_rdata)
   );

   // slot is free when empty or when the waiting beat leaves this cycle
   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_start = rsp_data_ff.match_start;
   assign rsp_is_match    = rsp_data_ff.is_match;
   assign rsp_any_found   = rsp_data_ff.any_found;
   assign rsp_last_result = rsp_data_ff.last_result;

endmodule

// ===== design/kmp_checker.sv =====
module kmp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_action,
   input logic [kmp_pkg::SYMBOL_W-1:0] req_symbol,
   input logic                         req_final_symbol,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [kmp_pkg::START_W-1:0]  rsp_match_start,
   input logic                         rsp_is_match,
   input logic                         rsp_any_found,
   input logic                         rsp_last_result
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_start)
         && $stable(rsp_is_match) && $stable(rsp_last_result))
      else $error("result beat changed while stalled");

   // an end marker is always the last result and carries no position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_match |-> rsp_last_result && (rsp_match_start == '0))
      else $error("end marker malformed");

   // a reported occurrence always shows something found
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_match |-> rsp_any_found)
      else $error("occurrence without any_found");

   // the final pattern byte starts the table build, so input stalls next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == kmp_pkg::ACT_PATTERN) && req_final_symbol
         |=> !req_ready)
      else $error("input taken during table build");

   // the last text byte is never followed by a beat back to back
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == kmp_pkg::ACT_TEXT) && req_final_symbol
         |=> !req_ready)
      else $error("last text byte accepted back to back");

endmodule

bind kmp_pattern_matcher_unit kmp_checker u_kmp_checker (.*);

// ===== tb/kmp_match_checker.sv =====
module kmp_match_checker #(
   parameter int PATTERN_MAX = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_action,
   input  logic [kmp_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                          req_final_symbol,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [kmp_pkg::START_W-1:0]   rsp_match_start,
   input  logic                          rsp_is_match,
   input  logic                          rsp_any_found,
   input  logic                          rsp_last_result,
   output int                            error_count,
   output int                            backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [kmp_pkg::SYMBOL_W-1:0] pattern_mem [PATTERN_MAX];
   logic [LEN_W-1:0]             prefix_mem [PATTERN_MAX];
   logic [LEN_W-1:0]             pattern_len;
   logic [LEN_W-1:0]             matched_len;
   logic [kmp_pkg::START_W-1:0]  text_pos;
   logic                         found_any;
   logic                         pattern_armed;
   kmp_pkg::result_type          pending_results [$];

   function automatic void clear_text();
      matched_len = '0;
      text_pos    = '0;
      found_any   = 1'b0;
   endfunction

   // classic prefix table over the stored pattern
   function automatic void build_prefix_table();
      int i;
      int k;
      i = 1;
      k = 0;
      if (pattern_len == 0)
         return;
      prefix_mem[0] = '0;
      while (i < pattern_len) begin
         if (pattern_mem[i] == pattern_mem[k]) begin
            k++;
            prefix_mem[i] = LEN_W'(k);
            i++;
         end else if (k == 0) begin
            prefix_mem[i] = '0;
            i++;
         end else begin
            k = int'(prefix_mem[k-1]);
         end
      end
   endfunction

   function automatic void search_step(input logic action,
                                       input logic [kmp_pkg::SYMBOL_W-1:0] sym,
                                       input logic last);
      kmp_pkg::result_type         expected;
      logic [kmp_pkg::START_W-1:0] here;
      logic                        hit;
      hit      = 1'b0;
      expected = '0;
      if (action == kmp_pkg::ACT_PATTERN) begin
         if (pattern_armed) begin
            pattern_armed = 1'b0;
            pattern_len   = '0;
            clear_text();
         end
         if (pattern_len < PATTERN_MAX) begin
            pattern_mem[pattern_len] = sym;
            pattern_len++;
         end
         if (last) begin
            build_prefix_table();
            pattern_armed = 1'b1;
            clear_text();
         end
      end else begin
         here = text_pos;
         if (text_pos != '1)
            text_pos++;
         if (pattern_armed && pattern_len != 0) begin
            while (matched_len != 0 && pattern_mem[matched_len] != sym)
               matched_len = prefix_mem[matched_len-1];
            if (pattern_mem[matched_len] == sym)
               matched_len++;
            if (matched_len == pattern_len) begin
               hit                  = 1'b1;
               expected.match_start = here + 1'b1 - kmp_pkg::START_W'(pattern_len);
               found_any            = 1'b1;
               matched_len          = prefix_mem[pattern_len-1];
            end
         end
         if (hit || last) begin
            expected.is_match    = hit;
            expected.any_found   = found_any;
            expected.last_result = last;
            pending_results.push_back(expected);
            if (last)
               clear_text();
         end
      end
   endfunction

   function automatic void report_failure(input string what,
                                          input kmp_pkg::result_type want,
                                          input kmp_pkg::result_type got);
      if (error_count < 10)
         $display({"%0t %s: expected start %0d match %0b found %0b last %0b, ",
                   "got start %0d match %0b found %0b last %0b"},
                  $time, what, want.match_start, want.is_match, want.any_found,
                  want.last_result, got.match_start, got.is_match, got.any_found,
                  got.last_result);
      error_count++;
   endfunction

   function automatic void check_result();
      kmp_pkg::result_type want;
      kmp_pkg::result_type got;
      got = '{match_start: rsp_match_start, is_match: rsp_is_match,
              any_found: rsp_any_found, last_result: rsp_last_result};
      if (pending_results.size() == 0) begin
         report_failure("unexpected result beat", '0, got);
      end else begin
         want = pending_results.pop_front();
         if (got.match_start !== want.match_start || got.is_match !== want.is_match ||
             got.any_found !== want.any_found || got.last_result !== want.last_result)
            report_failure("result beat mismatch", want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pattern_len   = '0;
         pattern_armed = 1'b0;
         error_count   = 0;
         clear_text();
         pending_results.delete();
      end else begin
         if (req_valid && req_ready)
            search_step(req_action, req_symbol, req_final_symbol);
         if (rsp_valid && rsp_ready)
            check_result();
      end
      backlog = pending_results.size();
   end

endmodule

// ===== tb/kmp_pattern_matcher_unit_test.sv =====
module kmp_pattern_matcher_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // generous: several times what a correct run needs under the longest stalls
   localparam int CYCLE_LIMIT   = 200_000;
   // covers a full prefix table build after the last beat
   localparam int SETTLE_CYCLES = 300;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_action;
   logic [kmp_pkg::SYMBOL_W-1:0] req_symbol;
   logic                         req_final_symbol;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [kmp_pkg::START_W-1:0]  rsp_match_start;
   logic                         rsp_is_match;
   logic                         rsp_any_found;
   logic                         rsp_last_result;

   int error_count;
   int backlog;
   int send_idle_pct = 14;
   int recv_idle_pct = 57;
   int hold_left     = 0;
   int beats_sent    = 0;
   int cycle_count   = 0;

   kmp_pattern_matcher_unit dut (.*);

   kmp_match_checker match_check (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one request beat: random idle gap first, then hold valid until accepted
   // enters and leaves on a falling edge
   task automatic offer_beat(input logic action, input logic [kmp_pkg::SYMBOL_W-1:0] symbol,
                             input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_action       = action;
      req_symbol       = symbol;
      req_final_symbol = last;
      do
         @(posedge clock);
      while (!req_ready);
      beats_sent++;
      @(negedge clock);
   endtask

   // sender goes quiet until every predicted result beat has come back
   task automatic pause_until_drained();
      req_valid = 1'b0;
      while (backlog != 0)
         @(negedge clock);
   endtask

   // receiver holds off for a long stretch while a single-byte pattern hits
   // on every text byte, so results pile up and the input stalls
   task automatic stall_receiver_burst();
      int n;
      hold_left = 400;
      offer_beat(kmp_pkg::ACT_PATTERN, 8'hC3, 1'b1);
      for (n = 0; n < 30; n++)
         offer_beat(kmp_pkg::ACT_TEXT, 8'hC3, n == 29);
   endtask

   // mostly a well formed pattern plus a few texts built from a small alphabet,
   // seeded with copies of the pattern; some noise and some broken texts
   task automatic random_session();
      logic [kmp_pkg::SYMBOL_W-1:0] alphabet [3];
      logic [kmp_pkg::SYMBOL_W-1:0] pattern_bytes [$];
      logic [kmp_pkg::SYMBOL_W-1:0] text_bytes [$];
      int                           alpha_size;
      int                           plen;
      int                           tlen;
      int                           k;
      if ($urandom_range(99) < 12) begin
         // noise: any action, any byte, random end flags
         repeat ($urandom_range(1, 12))
            offer_beat(1'($urandom_range(1)), 8'($urandom_range(255)),
                       $urandom_range(99) < 25);
         return;
      end
      alpha_size = $urandom_range(1, 3);
      for (k = 0; k < 3; k++)
         alphabet[k] = 8'($urandom_range(255));
      // a few patterns run past the pattern store and get truncated
      plen = ($urandom_range(99) < 5) ? $urandom_range(60, 72) : $urandom_range(1, 6);
      for (k = 0; k < plen; k++) begin
         pattern_bytes.push_back(alphabet[$urandom_range(alpha_size - 1)]);
         offer_beat(kmp_pkg::ACT_PATTERN, pattern_bytes[k], k == plen - 1);
      end
      repeat ($urandom_range(1, 3)) begin
         tlen = (plen > 8) ? $urandom_range(plen, 2 * plen + 10) : $urandom_range(1, 30);
         text_bytes.delete();
         while (text_bytes.size() < tlen) begin
            if ($urandom_range(99) < 30)
               text_bytes = {text_bytes, pattern_bytes};
            else
               text_bytes.push_back(alphabet[$urandom_range(alpha_size - 1)]);
         end
         for (k = 0; k < text_bytes.size(); k++) begin
            // rare pattern byte in mid text throws the pattern away
            if ($urandom_range(999) < 8)
               offer_beat(kmp_pkg::ACT_PATTERN, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            offer_beat(kmp_pkg::ACT_TEXT, text_bytes[k], k == text_bytes.size() - 1);
         end
      end
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("kmp_pattern_matcher_unit_test NOT OK");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = kmp_pkg::ACT_TEXT;
      req_symbol       = '0;
      req_final_symbol = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // text with no pattern loaded yet: end marker only, nothing found
      offer_beat(kmp_pkg::ACT_TEXT, 8'h00, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'hFF, 1'b1);
      // overlapping hits, the last one on the final text byte
      offer_beat(kmp_pkg::ACT_PATTERN, 8'h61, 1'b0);
      offer_beat(kmp_pkg::ACT_PATTERN, 8'h61, 1'b1);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h61, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h61, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h61, 1'b1);
      // fresh text after the end: the pattern is kept, found flag cleared
      offer_beat(kmp_pkg::ACT_TEXT, 8'h62, 1'b1);
      // single byte pattern at the top of the byte range
      offer_beat(kmp_pkg::ACT_PATTERN, 8'hFF, 1'b1);
      offer_beat(kmp_pkg::ACT_TEXT, 8'hFF, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h00, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'hFF, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h00, 1'b1);
      // pattern beat in the middle of a text starts a new pattern
      offer_beat(kmp_pkg::ACT_PATTERN, 8'h01, 1'b0);
      offer_beat(kmp_pkg::ACT_PATTERN, 8'h02, 1'b1);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h01, 1'b0);
      offer_beat(kmp_pkg::ACT_PATTERN, 8'h7F, 1'b0);
      offer_beat(kmp_pkg::ACT_PATTERN, 8'h80, 1'b1);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h7F, 1'b0);
      offer_beat(kmp_pkg::ACT_TEXT, 8'h80, 1'b1);

      stall_receiver_burst();
      while (beats_sent < 400)
         random_session();
      pause_until_drained();

      send_idle_pct = 57;
      recv_idle_pct = 14;
      while (beats_sent < 800)
         random_session();
      pause_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (beats_sent < 1150)
         random_session();
      pause_until_drained();

      // let any stray result beat show up before the verdict
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && backlog == 0)
         $display("kmp_pattern_matcher_unit_test OK");
      else
         $display("kmp_pattern_matcher_unit_test NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
design/kmp_pkg.sv
design/kmp_ram.sv
design/kmp_ctrl.sv
design/kmp_pattern_matcher_unit.sv
design/kmp_checker.sv
tb/kmp_match_checker.sv
tb/kmp_pattern_matcher_unit_test.sv
